// File: hdl/bmp565_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and color packing functions of the BMP to RGB565 converter.
// No dependencies; imported by the channel interfaces and the converter.
package bmp565_pkg;

  localparam int unsigned PAL_IDX_BITS_DEF = 8;
  localparam int unsigned DIM_BITS_DEF     = 12;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAL_IN_W   = 8;
  localparam int unsigned PAL_WORD_W = 24;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DEPTH_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SUB_PIX    = 8;
  localparam int unsigned SUB_SEL_W  = 3;
  localparam int unsigned GATHER_W   = 24;

  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_565       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_ROW_PIXELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_ROW_PIXELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_ROWS       = 3'd4;

  // Blue in bits 7..0, green 15..8, red 23..16; keep the top bits of each.
  function automatic logic [PIX_W-1:0] rgb888_to_565(input logic [GATHER_W-1:0] w);
    return {w[23:19], w[15:10], w[7:3]};
  endfunction

  // Drop the spare top bit and leave the green LSB clear.
  function automatic logic [PIX_W-1:0] rgb555_to_565(input logic [BYTE_W-1:0] lo,
                                                     input logic [BYTE_W-1:0] hi);
    return {hi[6:0], lo[7:5], 1'b0, lo[4:0]};
  endfunction

endpackage

// File: hdl/bmp565_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: raw BMP bytes and palette writes in, RGB565 pixels out.
// Depends on bmp565_pkg for field widths.
interface bmp565_in_if import bmp565_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [BYTE_W-1:0]     byte_value;
  logic [PAL_IN_W-1:0]   palette_index;
  logic [PAL_WORD_W-1:0] palette_word;

  modport source (output valid, kind, byte_value, palette_index, palette_word, input ready);
  modport sink (input valid, kind, byte_value, palette_index, palette_word, output ready);
endinterface

interface bmp565_out_if import bmp565_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_565;
  logic             end_of_row;
  logic             end_of_image;
  logic             last_of_run;

  modport source (output valid, pixel_565, end_of_row, end_of_image, last_of_run, input ready);
  modport sink (input valid, pixel_565, end_of_row, end_of_image, last_of_run, output ready);
endinterface

// File: hdl/bmp_pixel_to_rgb565_converter.sv
`timescale 1ns / 1ps
// BMP pixel array to RGB565 converter: byte framing, cropping and palette lookup.
// Depends on bmp565_pkg and the channel interfaces in bmp565_if.sv.
//
// Usage: in_i carries BMP pixel-array bytes (kind data), palette entry writes
// (kind palette) and image restarts; out_o carries RGB565 pixels with end of
// row, end of image and last-of-byte flags. The config port writes one register
// per cycle; write only while the block is idle, which the block does not check.
// Pixel path: the transfer of the byte that completes a pixel loads the job
// stage, and the job stage then loads the output register with the palette
// RAM read or the direct color.
// Throughput: one input transfer per cycle while out_o is ready, as long as
// each byte yields at most one pixel. A 4bpp or 1bpp byte issues its pixels
// one pixel per cycle, set by the single read port of the palette RAM.
// Reset: counters clear, registers take their defaults (24bpp, 555, one pixel
// per file row, nothing shown); palette RAM contents stay undefined until
// written.
// Stall: the output register holds its pixel while out_o.ready is low. Bytes
// transfer while the job stage is empty or issuing its last pixel; a byte with
// pixels holds the input until all of them are issued. Palette writes wait
// until pending palette reads are issued.
module bmp_pixel_to_rgb565_converter import bmp565_pkg::*; #(
  parameter int unsigned PALETTE_INDEX_BITS = PAL_IDX_BITS_DEF,
  parameter int unsigned DIMENSION_BITS     = DIM_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DIMENSION_BITS-1:0] cfg_wdata_i,
  bmp565_in_if.sink                 in_i,
  bmp565_out_if.source              out_o
);

  localparam int unsigned PAL_DEPTH = 1 << PALETTE_INDEX_BITS;
  localparam int unsigned DW        = DIMENSION_BITS;
  localparam int unsigned CNT_W     = DIMENSION_BITS + 2;
  localparam int unsigned RB_W      = DIMENSION_BITS + 6;
  localparam int unsigned TAKE_W    = 4;

  // configuration registers
  logic [DEPTH_W-1:0] depth_mode_q;
  logic               packed_565_q;
  logic [DW-1:0]      file_row_pixels_q;
  logic [DW-1:0]      shown_row_pixels_q;
  logic [DW-1:0]      shown_rows_q;

  // framing state
  logic [CNT_W-1:0]    row_byte_count_q, row_byte_count_d;
  logic [DW-1:0]       column_count_q, column_count_d;
  logic [DW-1:0]       row_count_q, row_count_d;
  logic [GATHER_W-1:0] byte_gather_q, byte_gather_d;
  logic [1:0]          byte_phase_q, byte_phase_d;

  // job stage: one accepted byte with its pixel slots
  logic                 j_valid_q, j_valid_d;
  logic [BYTE_W-1:0]    j_byte_q;
  logic [DEPTH_W-1:0]   j_mode_q;
  logic                 j_pal_q;
  logic [SUB_PIX-1:0]   j_mask_q, j_mask_d;
  logic [SUB_PIX-1:0]   j_eor_q;
  logic [SUB_PIX-1:0]   j_eoi_q;
  logic [PIX_W-1:0]     j_px_q;

  // output stage
  logic             r_valid_q;
  logic             r_pal_q;
  logic [PIX_W-1:0] r_px_q;
  logic             r_eor_q;
  logic             r_eoi_q;
  logic             r_last_q;

  // palette RAM
  logic [PIX_W-1:0]              pal_mem [PAL_DEPTH];
  logic [PIX_W-1:0]              pal_rdata_q;
  logic                          pal_we;
  logic                          pal_re;
  logic [PALETTE_INDEX_BITS-1:0] pal_raddr;

  // combinational
  logic                in_accept;
  logic                acc_data;
  logic                acc_pal;
  logic                acc_restart;
  logic [DEPTH_W-1:0]  mode_eff;
  logic                mode_pal;
  logic [DW-1:0]       fp;
  logic [DW-1:0]       eff;
  logic [RB_W-1:0]     fp_w;
  logic [RB_W-1:0]     row_bits;
  logic [CNT_W-1:0]    data_bytes;
  logic [CNT_W-1:0]    stride;
  logic [CNT_W-1:0]    rbc_inc;
  logic                in_data_row;
  logic                row_ok;
  logic                last_row;
  logic [GATHER_W-1:0] gather_or;
  logic [GATHER_W-1:0] gather_new;
  logic [1:0]          phase_new;
  logic                px_ready;
  logic [PIX_W-1:0]    direct_px;
  logic [1:0]          last_phase;
  logic [SUB_PIX-1:0]  take_en;
  logic [SUB_PIX-1:0]  slot_in_row;
  logic [SUB_PIX-1:0]  emit;
  logic [SUB_PIX-1:0]  eor;
  logic [SUB_PIX-1:0]  eoi;
  logic [TAKE_W-1:0]   take_cnt;
  logic [DW:0]         col_k;
  logic [DW:0]         fp_x;
  logic [DW:0]         eff_x;

  logic [SUB_SEL_W-1:0] sel;
  logic [SUB_PIX-1:0]   j_mask_rest;
  logic                 j_last;
  logic                 r_adv;
  logic                 j_issue;
  logic [BYTE_W-1:0]    sub_idx;

  assign in_accept   = in_i.valid && in_i.ready;
  assign acc_data    = in_accept && (in_i.kind == KIND_DATA);
  assign acc_pal     = in_accept && (in_i.kind == KIND_PAL);
  assign acc_restart = in_accept && (in_i.kind == KIND_RESTART);

  // ---------------------------------------------------------------- row geometry
  always_comb begin
    mode_eff = (depth_mode_q > DEPTH_32BPP) ? DEPTH_32BPP : depth_mode_q;
    mode_pal = (mode_eff == DEPTH_1BPP) || (mode_eff == DEPTH_4BPP) ||
               (mode_eff == DEPTH_8BPP);
    fp       = (file_row_pixels_q == '0) ? DW'(1) : file_row_pixels_q;
    eff      = (shown_row_pixels_q < fp) ? shown_row_pixels_q : fp;
    fp_w     = RB_W'(fp);
    unique case (mode_eff)
      DEPTH_1BPP:  row_bits = fp_w;
      DEPTH_4BPP:  row_bits = fp_w << 2;
      DEPTH_8BPP:  row_bits = fp_w << 3;
      DEPTH_16BPP: row_bits = fp_w << 4;
      DEPTH_24BPP: row_bits = (fp_w << 4) + (fp_w << 3);
      default:     row_bits = fp_w << 5;
    endcase
    data_bytes  = CNT_W'((row_bits + RB_W'(7)) >> 3);
    stride      = CNT_W'(((row_bits + RB_W'(31)) >> 5) << 2);
    rbc_inc     = row_byte_count_q + CNT_W'(1);
    in_data_row = row_byte_count_q < data_bytes;
    row_ok      = row_count_q < shown_rows_q;
    last_row    = row_count_q == (shown_rows_q - DW'(1));
  end

  // ---------------------------------------------------------------- direct color gather
  always_comb begin
    gather_or = byte_gather_q;
    unique case (byte_phase_q)
      2'd0:    gather_or[7:0]   = byte_gather_q[7:0] | in_i.byte_value;
      2'd1:    gather_or[15:8]  = byte_gather_q[15:8] | in_i.byte_value;
      2'd2:    gather_or[23:16] = byte_gather_q[23:16] | in_i.byte_value;
      default: gather_or = byte_gather_q;
    endcase
    last_phase = (mode_eff == DEPTH_24BPP) ? 2'd2 : 2'd3;
    gather_new = byte_gather_q;
    phase_new  = byte_phase_q;
    px_ready   = 1'b0;
    direct_px  = rgb888_to_565(gather_or);
    if (mode_eff == DEPTH_16BPP) begin
      if (byte_phase_q == 2'd0) begin
        gather_new = GATHER_W'(in_i.byte_value);
        phase_new  = 2'd1;
      end else begin
        direct_px  = packed_565_q ? {in_i.byte_value, byte_gather_q[7:0]}
                                  : rgb555_to_565(byte_gather_q[7:0], in_i.byte_value);
        gather_new = '0;
        phase_new  = 2'd0;
        px_ready   = 1'b1;
      end
    end else if (!mode_pal) begin
      if (byte_phase_q >= last_phase) begin
        gather_new = '0;
        phase_new  = 2'd0;
        px_ready   = 1'b1;
      end else begin
        gather_new = gather_or;
        phase_new  = byte_phase_q + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------- pixel slots of this byte
  always_comb begin
    unique case (mode_eff)
      DEPTH_1BPP: take_en = 8'hFF;
      DEPTH_4BPP: take_en = 8'h03;
      DEPTH_8BPP: take_en = 8'h01;
      default:    take_en = px_ready ? 8'h01 : 8'h00;
    endcase
    if (!in_data_row) begin
      take_en = '0;
    end
    fp_x     = (DW+1)'(fp);
    eff_x    = (DW+1)'(eff);
    take_cnt = '0;
    col_k    = '0;
    for (int k = 0; k < SUB_PIX; k++) begin
      col_k          = (DW+1)'(column_count_q) + (DW+1)'(k);
      slot_in_row[k] = take_en[k] && (col_k < fp_x);
      emit[k]        = slot_in_row[k] && row_ok && (col_k < eff_x);
      eor[k]         = emit[k] && (col_k == (eff_x - (DW+1)'(1)));
      eoi[k]         = eor[k] && last_row;
      if (slot_in_row[k]) begin
        take_cnt = take_cnt + TAKE_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- framing next state
  always_comb begin
    row_byte_count_d = row_byte_count_q;
    column_count_d   = column_count_q;
    row_count_d      = row_count_q;
    byte_gather_d    = byte_gather_q;
    byte_phase_d     = byte_phase_q;
    if (acc_data) begin
      if (in_data_row) begin
        column_count_d = column_count_q + DW'(take_cnt);
        byte_gather_d  = gather_new;
        byte_phase_d   = phase_new;
      end
      row_byte_count_d = rbc_inc;
      // drop the row padding and start the next row
      if (rbc_inc >= stride) begin
        row_byte_count_d = '0;
        column_count_d   = '0;
        byte_gather_d    = '0;
        byte_phase_d     = 2'd0;
        if (row_count_q != '1) begin
          row_count_d = row_count_q + DW'(1);
        end
      end
    end else if (acc_restart) begin
      row_byte_count_d = '0;
      column_count_d   = '0;
      row_count_d      = '0;
      byte_gather_d    = '0;
      byte_phase_d     = 2'd0;
    end
  end

  // ---------------------------------------------------------------- job issue
  always_comb begin
    sel = '0;
    for (int k = SUB_PIX - 1; k >= 0; k--) begin
      if (j_mask_q[k]) begin
        sel = SUB_SEL_W'(k);
      end
    end
    j_mask_rest = j_mask_q & ~(SUB_PIX'(1) << sel);
    j_last      = (j_mask_rest == '0);
    r_adv       = !r_valid_q || out_o.ready;
    j_issue     = j_valid_q && r_adv;
    unique case (j_mode_q)
      DEPTH_1BPP: sub_idx = BYTE_W'(j_byte_q[SUB_SEL_W'(SUB_PIX - 1) - sel]);
      DEPTH_4BPP: sub_idx = sel[0] ? BYTE_W'(j_byte_q[3:0]) : BYTE_W'(j_byte_q[7:4]);
      default:    sub_idx = j_byte_q;
    endcase
    pal_raddr = sub_idx[PALETTE_INDEX_BITS-1:0];
    pal_re    = j_issue && j_pal_q;
    pal_we    = acc_pal;

    j_valid_d = j_valid_q;
    j_mask_d  = j_mask_q;
    if (j_issue) begin
      j_mask_d = j_mask_rest;
      if (j_last) begin
        j_valid_d = 1'b0;
      end
    end
    if (acc_data && (emit != '0)) begin
      j_valid_d = 1'b1;
      j_mask_d  = emit;
    end
  end

  // hold new input while a job still has pixels left to issue
  assign in_i.ready = !j_valid_q || (j_issue && j_last);

  // ---------------------------------------------------------------- palette RAM
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[in_i.palette_index[PALETTE_INDEX_BITS-1:0]] <= rgb888_to_565(in_i.palette_word);
    end
    if (pal_re) begin
      pal_rdata_q <= pal_mem[pal_raddr];
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q       <= DEPTH_24BPP;
      packed_565_q       <= 1'b0;
      file_row_pixels_q  <= DW'(1);
      shown_row_pixels_q <= '0;
      shown_rows_q       <= '0;
      row_byte_count_q   <= '0;
      column_count_q     <= '0;
      row_count_q        <= '0;
      byte_gather_q      <= '0;
      byte_phase_q       <= 2'd0;
      j_valid_q          <= 1'b0;
      j_mask_q           <= '0;
      r_valid_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEPTH_MODE:       depth_mode_q       <= cfg_wdata_i[DEPTH_W-1:0];
          CFG_PACKED_565:       packed_565_q       <= cfg_wdata_i[0];
          CFG_FILE_ROW_PIXELS:  file_row_pixels_q  <= cfg_wdata_i;
          CFG_SHOWN_ROW_PIXELS: shown_row_pixels_q <= cfg_wdata_i;
          CFG_SHOWN_ROWS:       shown_rows_q       <= cfg_wdata_i;
          default: ;
        endcase
      end
      row_byte_count_q <= row_byte_count_d;
      column_count_q   <= column_count_d;
      row_count_q      <= row_count_d;
      byte_gather_q    <= byte_gather_d;
      byte_phase_q     <= byte_phase_d;
      j_valid_q        <= j_valid_d;
      j_mask_q         <= j_mask_d;
      if (r_adv) begin
        r_valid_q <= j_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_data && (emit != '0)) begin
      j_byte_q <= in_i.byte_value;
      j_mode_q <= mode_eff;
      j_pal_q  <= mode_pal;
      j_eor_q  <= eor;
      j_eoi_q  <= eoi;
      j_px_q   <= direct_px;
    end
    if (j_issue) begin
      r_pal_q  <= j_pal_q;
      r_px_q   <= j_px_q;
      r_eor_q  <= j_eor_q[sel];
      r_eoi_q  <= j_eoi_q[sel];
      r_last_q <= j_last;
    end
  end

  assign out_o.valid        = r_valid_q;
  assign out_o.pixel_565    = r_pal_q ? pal_rdata_q : r_px_q;
  assign out_o.end_of_row   = r_eor_q;
  assign out_o.end_of_image = r_eoi_q;
  assign out_o.last_of_run  = r_last_q;

endmodule
